### hdl/obb_sat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_sat_pkg
// Shared constants for the oriented box overlap unit: word field width,
// default fixed-point format, axis and term counts, pipeline depth.
// ----------------------------------------------------------------------------
package obb_sat_pkg;

  // Width of every packed input field (three components of the default width)
  localparam int unsigned FIELD_W = 63;

  // Default fixed-point format of one component
  localparam int unsigned COMPONENT_WIDTH_DEF = 21;
  localparam int unsigned FRACTION_BITS_DEF   = 16;

  // Vectors dotted against each axis: center offset, three A axes, three B axes
  localparam int unsigned NUM_VEC  = 7;
  // Half extents: three of box A, three of box B
  localparam int unsigned NUM_EXT  = 6;
  // Three face axes of A, three of B, nine cross axes
  localparam int unsigned NUM_AXES = 15;

  // Register stages from input to result
  localparam int unsigned PIPE_DEPTH = 9;

endpackage

### hdl/obb_sat_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_sat_in_if
// Input channel: one box pair per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface obb_sat_in_if;
  import obb_sat_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] rel_position;
  logic [FIELD_W-1:0] a_axis_x;
  logic [FIELD_W-1:0] a_axis_y;
  logic [FIELD_W-1:0] a_axis_z;
  logic [FIELD_W-1:0] a_half_extents;
  logic [FIELD_W-1:0] b_axis_x;
  logic [FIELD_W-1:0] b_axis_y;
  logic [FIELD_W-1:0] b_axis_z;
  logic [FIELD_W-1:0] b_half_extents;

  modport source (
    output valid, rel_position, a_axis_x, a_axis_y, a_axis_z, a_half_extents,
    output b_axis_x, b_axis_y, b_axis_z, b_half_extents,
    input  ready
  );

  modport sink (
    input  valid, rel_position, a_axis_x, a_axis_y, a_axis_z, a_half_extents,
    input  b_axis_x, b_axis_y, b_axis_z, b_half_extents,
    output ready
  );

endinterface

### hdl/obb_sat_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_sat_out_if
// Result channel: one overlap flag per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface obb_sat_out_if;

  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink   (input valid, overlap, output ready);

endinterface

### hdl/obb_obb_overlap_sat_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_obb_overlap_sat_unit
// Separating axis test of two oriented boxes over all fifteen candidate axes.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one box pair per word: center offset, three axes and the
//         half extents of each box, each field three signed components.
//   out_o carries one word per input word: overlap = 1 when no axis
//         separates the boxes (touching counts as overlap), else 0.
//   Words leave in the order they enter.
// Stages and throughput:
//   Nine register stages. One word is taken each cycle while in_i is ready
//   (see Stalls); the multiplier banks of every stage are fully replicated,
//   so the dot-product stage (105 three-term dots) sets the stage depth.
// Reset:
//   rst_ni clears all stage valid bits; the pipe is empty and ready.
// Stalls:
//   Each stage holds while the next one is full and holding; a stage with a
//   bubble keeps filling, so in_i stays ready until all nine stages are full
//   behind a stalled receiver. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module obb_obb_overlap_sat_unit #(
  parameter int unsigned COMPONENT_WIDTH = obb_sat_pkg::COMPONENT_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS   = obb_sat_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  obb_sat_in_if.sink    in_i,
  obb_sat_out_if.source out_o
);
  import obb_sat_pkg::*;

  localparam int unsigned W   = COMPONENT_WIDTH;
  localparam int unsigned F   = FRACTION_BITS;
  // cross-axis component: difference of two W x W products
  localparam int unsigned CW  = 2 * W + 1;
  // signed dot product of a component vector with an axis
  localparam int unsigned DW  = 3 * W + 3;
  // split of the dot magnitude for the extent multiply
  localparam int unsigned H   = (DW + 1) / 2;
  localparam int unsigned HW  = DW - H;
  // magnitude times extent
  localparam int unsigned PW  = DW + W;
  // compare width, holds both sides
  localparam int unsigned SW  = DW + W + F + 3;
  localparam int unsigned NS  = PIPE_DEPTH;

  // --------------------------------------------------------------------------
  // Stage control: a stage advances when it is empty or its successor moves
  // --------------------------------------------------------------------------
  logic [NS:1] v_q, v_d, en;

  always_comb begin
    en[NS] = !v_q[NS] || out_o.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    v_d[1] = in_i.valid;
    for (int k = 2; k <= NS; k++) begin
      v_d[k] = v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) v_q[k] <= v_d[k];
      end
    end
  end

  assign in_i.ready = en[1];

  // --------------------------------------------------------------------------
  // Stage 1: unpack, build the fifteen axes (cross axes are B_j x A_i)
  // --------------------------------------------------------------------------
  logic signed [W-1:0]  vin  [NUM_VEC][3];
  logic signed [W-1:0]  ein  [NUM_EXT];
  logic signed [CW-1:0] axis_d [NUM_AXES][3];
  logic signed [CW-1:0] axis_q [NUM_AXES][3];
  logic signed [W-1:0]  vec_q  [NUM_VEC][3];
  logic signed [W-1:0]  ext1_q [NUM_EXT];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vin[0][c] = in_i.rel_position[c*W +: W];
      vin[1][c] = in_i.a_axis_x[c*W +: W];
      vin[2][c] = in_i.a_axis_y[c*W +: W];
      vin[3][c] = in_i.a_axis_z[c*W +: W];
      vin[4][c] = in_i.b_axis_x[c*W +: W];
      vin[5][c] = in_i.b_axis_y[c*W +: W];
      vin[6][c] = in_i.b_axis_z[c*W +: W];
      ein[c]     = in_i.a_half_extents[c*W +: W];
      ein[3 + c] = in_i.b_half_extents[c*W +: W];
    end
  end

  always_comb begin
    // face axes, unscaled: both sides of the test drop the same factor
    for (int i = 0; i < 6; i++) begin
      for (int c = 0; c < 3; c++) begin
        axis_d[i][c] = CW'(vin[1+i][c]);
      end
    end
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        axis_d[6+3*j+i][0] = CW'(vin[4+j][1]) * CW'(vin[1+i][2])
                           - CW'(vin[4+j][2]) * CW'(vin[1+i][1]);
        axis_d[6+3*j+i][1] = CW'(vin[4+j][2]) * CW'(vin[1+i][0])
                           - CW'(vin[4+j][0]) * CW'(vin[1+i][2]);
        axis_d[6+3*j+i][2] = CW'(vin[4+j][0]) * CW'(vin[1+i][1])
                           - CW'(vin[4+j][1]) * CW'(vin[1+i][0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      axis_q <= axis_d;
      vec_q  <= vin;
      ext1_q <= ein;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: dot every vector with every axis
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] dot_d [NUM_AXES][NUM_VEC];
  logic signed [DW-1:0] dot_q [NUM_AXES][NUM_VEC];
  logic signed [W-1:0]  ext2_q [NUM_EXT];

  always_comb begin
    for (int x = 0; x < NUM_AXES; x++) begin
      for (int v = 0; v < NUM_VEC; v++) begin
        dot_d[x][v] = DW'(vec_q[v][0]) * DW'(axis_q[x][0])
                    + DW'(vec_q[v][1]) * DW'(axis_q[x][1])
                    + DW'(vec_q[v][2]) * DW'(axis_q[x][2]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      dot_q  <= dot_d;
      ext2_q <= ext1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: magnitudes of dots and extents
  // --------------------------------------------------------------------------
  logic [DW-1:0] mag_d [NUM_AXES][NUM_VEC];
  logic [DW-1:0] mag_q [NUM_AXES][NUM_VEC];
  logic [W-1:0]  emag_d [NUM_EXT];
  logic [W-1:0]  emag_q [NUM_EXT];

  always_comb begin
    for (int x = 0; x < NUM_AXES; x++) begin
      for (int v = 0; v < NUM_VEC; v++) begin
        mag_d[x][v] = dot_q[x][v][DW-1] ? DW'(-dot_q[x][v]) : DW'(dot_q[x][v]);
      end
    end
    for (int t = 0; t < NUM_EXT; t++) begin
      emag_d[t] = ext2_q[t][W-1] ? W'(-ext2_q[t]) : W'(ext2_q[t]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      mag_q  <= mag_d;
      emag_q <= emag_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: projected extents as two half-width partial products
  // --------------------------------------------------------------------------
  logic [H+W-1:0]  plo_d [NUM_AXES][NUM_EXT];
  logic [H+W-1:0]  plo_q [NUM_AXES][NUM_EXT];
  logic [HW+W-1:0] phi_d [NUM_AXES][NUM_EXT];
  logic [HW+W-1:0] phi_q [NUM_AXES][NUM_EXT];
  logic [DW-1:0]   lhs4_q [NUM_AXES];

  always_comb begin
    for (int x = 0; x < NUM_AXES; x++) begin
      for (int t = 0; t < NUM_EXT; t++) begin
        plo_d[x][t] = (H+W)'(mag_q[x][1+t][H-1:0]) * (H+W)'(emag_q[t]);
        phi_d[x][t] = (HW+W)'(mag_q[x][1+t][DW-1:H]) * (HW+W)'(emag_q[t]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      for (int x = 0; x < NUM_AXES; x++) lhs4_q[x] <= mag_q[x][0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: merge partial products
  // --------------------------------------------------------------------------
  logic [PW-1:0] prod_d [NUM_AXES][NUM_EXT];
  logic [PW-1:0] prod_q [NUM_AXES][NUM_EXT];
  logic [DW-1:0] lhs5_q [NUM_AXES];

  always_comb begin
    for (int x = 0; x < NUM_AXES; x++) begin
      for (int t = 0; t < NUM_EXT; t++) begin
        prod_d[x][t] = (PW'(phi_q[x][t]) << H) + PW'(plo_q[x][t]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      prod_q <= prod_d;
      lhs5_q <= lhs4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: add A and B terms pairwise
  // --------------------------------------------------------------------------
  logic [PW:0]   pair_d [NUM_AXES][3];
  logic [PW:0]   pair_q [NUM_AXES][3];
  logic [DW-1:0] lhs6_q [NUM_AXES];

  always_comb begin
    for (int x = 0; x < NUM_AXES; x++) begin
      for (int k = 0; k < 3; k++) begin
        pair_d[x][k] = (PW+1)'(prod_q[x][k]) + (PW+1)'(prod_q[x][3+k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      pair_q <= pair_d;
      lhs6_q <= lhs5_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: fold two pairs, carry the third
  // --------------------------------------------------------------------------
  logic [PW+1:0] s01_d [NUM_AXES];
  logic [PW+1:0] s01_q [NUM_AXES];
  logic [PW:0]   p2_q  [NUM_AXES];
  logic [DW-1:0] lhs7_q [NUM_AXES];

  always_comb begin
    for (int x = 0; x < NUM_AXES; x++) begin
      s01_d[x] = (PW+2)'(pair_q[x][0]) + (PW+2)'(pair_q[x][1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s01_q  <= s01_d;
      lhs7_q <= lhs6_q;
      for (int x = 0; x < NUM_AXES; x++) p2_q[x] <= pair_q[x][2];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: final sum and strict compare; a tie does not separate
  // --------------------------------------------------------------------------
  logic [NUM_AXES-1:0] sep_d, sep_q;

  always_comb begin
    for (int x = 0; x < NUM_AXES; x++) begin
      sep_d[x] = (SW'(lhs7_q[x]) << F) > (SW'(s01_q[x]) + SW'(p2_q[x]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) sep_q <= sep_d;
  end

  // --------------------------------------------------------------------------
  // Stage 9: output register; overlap when no axis separates
  // --------------------------------------------------------------------------
  logic ovl_d, ovl_q;

  assign ovl_d = ~|sep_q;

  always_ff @(posedge clk_i) begin
    if (en[9]) ovl_q <= ovl_d;
  end

  assign out_o.valid   = v_q[NS];
  assign out_o.overlap = ovl_q;

endmodule

### hdl/obb_sat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_sat_checker
// Port-level checks of the overlap unit: word count in flight and output hold.
// ----------------------------------------------------------------------------
module obb_sat_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic overlap_i
);
  import obb_sat_pkg::*;

  localparam int unsigned CNTW = $clog2(PIPE_DEPTH + 1) + 1;

  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q + CNTW'(in_acc) - CNTW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(overlap_i))
    else $error("stalled result word changed or dropped");

  // no result word without an accepted input word
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result word with nothing in flight");

  // never more words in flight than stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(PIPE_DEPTH))
    else $error("more words in flight than pipeline stages");

  // an empty unit takes a word
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> in_ready_i)
    else $error("empty unit not ready");

endmodule

bind obb_obb_overlap_sat_unit obb_sat_checker u_obb_sat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .overlap_i   (out_o.overlap)
);
